// ===== hdl/cyc_pkg.sv =====
// Shared types, register indexes and constants of the cylindrical Yee curl block.
`default_nettype none

package cyc_pkg;

    // Component selector codes.
    localparam logic [1:0] CMD_RADIAL    = 2'd0;
    localparam logic [1:0] CMD_AZIMUTHAL = 2'd1;
    localparam logic [1:0] CMD_AXIAL     = 2'd2;
    localparam logic [1:0] CMD_UNUSED    = 2'd3;

    // Configuration register indexes (byte address is four times the index).
    localparam int          CFG_AW           = 5;
    localparam logic [2:0]  REG_INNER_RADIUS = 3'd0;
    localparam logic [2:0]  REG_RADIAL_STEP  = 3'd1;
    localparam logic [2:0]  REG_INV_RADIAL   = 3'd2;
    localparam logic [2:0]  REG_INV_ANGULAR  = 3'd3;
    localparam logic [2:0]  REG_INV_AXIAL    = 3'd4;

    // Reset values of the registers.
    localparam logic [31:0] RST_INNER_RADIUS = 32'h0000_0000;
    localparam logic [31:0] RST_RADIAL_STEP  = 32'h1000_0000;
    localparam logic [31:0] RST_INV_STEP     = 32'h0000_1000;

    // Radii carry 28 fraction bits and up to 42 bits in all.
    localparam int RW = 42;

    // Quotient bits produced by the divider; larger quotients saturate.
    localparam int DIV_STEPS = 54;
    localparam int DIV_PRE   = DIV_STEPS - 28;

    // Intermediate clamp limit, 2^60.
    localparam logic [63:0] LIM64 = 64'h1000_0000_0000_0000;

    typedef struct packed {
        logic [31:0] inner_radius;
        logic [31:0] radial_step;
        logic [31:0] inv_radial;
        logic [31:0] inv_angular;
        logic [31:0] inv_axial;
    } cyc_cfg_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [8:0] ri;
        logic [7:0] aj;
        logic [8:0] zk;
    } cyc_tag_t;

    // Word handed from the operand pipeline to the divider.
    typedef struct packed {
        cyc_tag_t         tag;
        logic             use_div;
        logic             neg;
        logic             force_sat;
        logic [63:0]      offset;
        logic [RW-1:0]    divisor;
        logic [60:0]      mag;
    } cyc_div_in_t;

    // Word leaving the divider.
    typedef struct packed {
        cyc_tag_t         tag;
        logic             use_div;
        logic             neg;
        logic             force_sat;
        logic [63:0]      offset;
        logic [DIV_STEPS:0] quot;
    } cyc_div_out_t;

endpackage

`default_nettype wire

// ===== hdl/cylindrical_yee_curl_point.sv =====
// Top level of the cylindrical Yee curl block: ports, stall control and output register.
//
//  Channel  | Ports                     | Word
//  ---------+---------------------------+------------------------------------------
//  input    | s_tvalid/s_tready/s_tdata | indices and four Q16.16 samples, s_tuser
//  result   | m_tvalid/m_tready/m_tdata | curl value and indices, m_tuser flags
//  config   | psel/penable/pwrite/...   | five 32-bit registers at 4*index
//
// One word enters per cycle unless the output holds; each result passes six operand
// stages, a 55-stage divider (a setup stage, then one quotient bit per stage) and the
// output register. Reset (aresetn low, synchronous) clears all valid bits and loads
// the register defaults. When the result is not taken the whole pipeline holds.
`default_nettype none

module cylindrical_yee_curl_point (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // [8:0] radial_index, [16:9] angular_index, [25:17] axial_index,
    // [57:26] first_ahead, [89:58] first_here, [121:90] second_ahead,
    // [153:122] second_here, [159:154] zero
    input  wire logic [159:0]               s_tdata,
    // [1:0] command
    input  wire logic [1:0]                 s_tuser,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // [31:0] curl_value, [40:32] out_radial, [48:41] out_angular,
    // [57:49] out_axial, [63:58] zero
    output logic      [63:0]                m_tdata,
    // [1:0] out_component, [2] saturated
    output logic      [2:0]                 m_tuser,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [cyc_pkg::CFG_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready
);

    cyc_pkg::cyc_cfg_t     cfg;
    cyc_pkg::cyc_tag_t     in_tag;
    cyc_pkg::cyc_div_in_t  div_in;
    cyc_pkg::cyc_div_out_t div_out;
    logic                  div_in_valid, div_out_valid, adv;
    logic                  out_valid_reg;
    logic [31:0]           curl_reg;
    cyc_pkg::cyc_tag_t     tag_reg;
    logic                  sat_reg;
    logic [63:0]           sq, v;
    logic [31:0]           curl_next;
    logic                  sat_next;

    // The pipeline moves whenever the output register is free or being emptied.
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    assign in_tag.cmd = s_tuser;
    assign in_tag.ri  = s_tdata[8:0];
    assign in_tag.aj  = s_tdata[16:9];
    assign in_tag.zk  = s_tdata[25:17];

    cyc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cyc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .in_tag    (in_tag),
        .in_fa     (s_tdata[57:26]),
        .in_fh     (s_tdata[89:58]),
        .in_sa     (s_tdata[121:90]),
        .in_sh     (s_tdata[153:122]),
        .cfg       (cfg),
        .out_valid (div_in_valid),
        .out_data  (div_in)
    );

    cyc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (div_in_valid),
        .in_data   (div_in),
        .out_valid (div_out_valid),
        .out_data  (div_out)
    );

    // Signed quotient plus offset, then clipping to the Q16.16 range.
    assign sq = div_out.neg ? 64'd0 - 64'(div_out.quot) : 64'(div_out.quot);
    assign v  = (div_out.use_div ? sq : 64'd0) + div_out.offset;

    always_comb begin
        if ($signed(v) > 64'sd2147483647) begin
            curl_next = 32'h7FFF_FFFF;
            sat_next  = 1'b1;
        end else if ($signed(v) < -64'sd2147483648) begin
            curl_next = 32'h8000_0000;
            sat_next  = 1'b1;
        end else begin
            curl_next = v[31:0];
            sat_next  = div_out.force_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= div_out_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            curl_reg <= curl_next;
            tag_reg  <= div_out.tag;
            sat_reg  <= sat_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'h0, tag_reg.zk, tag_reg.aj, tag_reg.ri, curl_reg};
    assign m_tuser  = {sat_reg, tag_reg.cmd};

endmodule

`default_nettype wire

// ===== hdl/cyc_cfg_regs.sv =====
// APB configuration registers of the curl block.
`default_nettype none

module cyc_cfg_regs (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [cyc_pkg::CFG_AW-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready,
    output cyc_pkg::cyc_cfg_t              cfg
);

    logic [31:0] inner_radius_reg;
    logic [31:0] radial_step_reg;
    logic [31:0] inv_radial_reg;
    logic [31:0] inv_angular_reg;
    logic [31:0] inv_axial_reg;
    logic [2:0]  index;
    logic        wr_en;

    assign index  = paddr[cyc_pkg::CFG_AW-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register writes in the access cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inner_radius_reg <= cyc_pkg::RST_INNER_RADIUS;
            radial_step_reg  <= cyc_pkg::RST_RADIAL_STEP;
            inv_radial_reg   <= cyc_pkg::RST_INV_STEP;
            inv_angular_reg  <= cyc_pkg::RST_INV_STEP;
            inv_axial_reg    <= cyc_pkg::RST_INV_STEP;
        end else if (wr_en) begin
            unique case (index)
                cyc_pkg::REG_INNER_RADIUS: inner_radius_reg <= pwdata;
                cyc_pkg::REG_RADIAL_STEP:  radial_step_reg  <= pwdata;
                cyc_pkg::REG_INV_RADIAL:   inv_radial_reg   <= pwdata;
                cyc_pkg::REG_INV_ANGULAR:  inv_angular_reg  <= pwdata;
                cyc_pkg::REG_INV_AXIAL:    inv_axial_reg    <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back.
    always_comb begin
        unique case (index)
            cyc_pkg::REG_INNER_RADIUS: prdata = inner_radius_reg;
            cyc_pkg::REG_RADIAL_STEP:  prdata = radial_step_reg;
            cyc_pkg::REG_INV_RADIAL:   prdata = inv_radial_reg;
            cyc_pkg::REG_INV_ANGULAR:  prdata = inv_angular_reg;
            cyc_pkg::REG_INV_AXIAL:    prdata = inv_axial_reg;
            default:                   prdata = 32'h0;
        endcase
    end

    assign cfg.inner_radius = inner_radius_reg;
    assign cfg.radial_step  = radial_step_reg;
    assign cfg.inv_radial   = inv_radial_reg;
    assign cfg.inv_angular  = inv_angular_reg;
    assign cfg.inv_axial    = inv_axial_reg;

endmodule

`default_nettype wire

// ===== hdl/cyc_front.sv =====
// Operand pipeline: radii, differences, scaled terms and divider setup in six stages.
`default_nettype none

module cyc_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 adv,
    input  wire logic                 in_valid,
    input  wire cyc_pkg::cyc_tag_t    in_tag,
    input  wire logic [31:0]          in_fa,
    input  wire logic [31:0]          in_fh,
    input  wire logic [31:0]          in_sa,
    input  wire logic [31:0]          in_sh,
    input  wire cyc_pkg::cyc_cfg_t    cfg,
    output logic                      out_valid,
    output cyc_pkg::cyc_div_in_t      out_data
);

    localparam int RW = cyc_pkg::RW;

    // ---------------- stage 1: radii and differences ----------------
    logic              s1_valid_reg;
    cyc_pkg::cyc_tag_t s1_tag_reg;
    logic [31:0]       s1_fa_reg, s1_fh_reg;
    logic [32:0]       s1_d1_reg, s1_d2_reg;
    logic [RW-1:0]     s1_ri_reg, s1_rip1_reg, s1_rhalf_reg;
    logic [RW-1:0]     ri_next;

    assign ri_next = RW'(cfg.inner_radius) + RW'(in_tag.ri) * RW'(cfg.radial_step);

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_tag_reg   <= in_tag;
            s1_fa_reg    <= in_fa;
            s1_fh_reg    <= in_fh;
            s1_d1_reg    <= {in_fa[31], in_fa} - {in_fh[31], in_fh};
            s1_d2_reg    <= {in_sa[31], in_sa} - {in_sh[31], in_sh};
            s1_ri_reg    <= ri_next;
            s1_rip1_reg  <= ri_next + RW'(cfg.radial_step);
            s1_rhalf_reg <= ri_next + RW'(cfg.radial_step[31:1]);
        end
    end

    // ---------------- stage 2: products ----------------
    logic              s2_valid_reg;
    cyc_pkg::cyc_tag_t s2_tag_reg;
    logic [64:0]       s2_p1_reg, s2_p2_reg;
    logic              s2_neg1_reg, s2_neg2_reg, s2_nfa_reg, s2_nfh_reg;
    logic [63:0]       s2_fa_lo_reg, s2_fh_lo_reg;
    logic [41:0]       s2_fa_hi_reg, s2_fh_hi_reg;
    logic              s2_rz_reg, s2_hz_reg;
    logic [RW-1:0]     s2_div_reg;
    logic [32:0]       mag1, mag2;
    logic [31:0]       inv1, inv2, fam, fhm;

    assign mag1 = s1_d1_reg[32] ? 33'd0 - s1_d1_reg : s1_d1_reg;
    assign mag2 = s1_d2_reg[32] ? 33'd0 - s1_d2_reg : s1_d2_reg;
    assign fam  = s1_fa_reg[31] ? 32'd0 - s1_fa_reg : s1_fa_reg;
    assign fhm  = s1_fh_reg[31] ? 32'd0 - s1_fh_reg : s1_fh_reg;

    // Reciprocals that scale the two differences for each component.
    always_comb begin
        unique case (s1_tag_reg.cmd)
            cyc_pkg::CMD_RADIAL: begin
                inv1 = cfg.inv_angular;
                inv2 = cfg.inv_axial;
            end
            cyc_pkg::CMD_AZIMUTHAL: begin
                inv1 = cfg.inv_axial;
                inv2 = cfg.inv_radial;
            end
            cyc_pkg::CMD_AXIAL: begin
                inv1 = cfg.inv_axial;
                inv2 = cfg.inv_angular;
            end
            cyc_pkg::CMD_UNUSED: begin
                inv1 = 32'h0;
                inv2 = 32'h0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_tag_reg   <= s1_tag_reg;
            s2_p1_reg    <= 65'(mag1) * 65'(inv1);
            s2_p2_reg    <= 65'(mag2) * 65'(inv2);
            s2_neg1_reg  <= s1_d1_reg[32];
            s2_neg2_reg  <= s1_d2_reg[32];
            s2_nfa_reg   <= s1_fa_reg[31];
            s2_nfh_reg   <= s1_fh_reg[31];
            s2_fa_lo_reg <= 64'(fam) * 64'(s1_rip1_reg[31:0]);
            s2_fa_hi_reg <= 42'(fam) * 42'(s1_rip1_reg[RW-1:32]);
            s2_fh_lo_reg <= 64'(fhm) * 64'(s1_ri_reg[31:0]);
            s2_fh_hi_reg <= 42'(fhm) * 42'(s1_ri_reg[RW-1:32]);
            s2_rz_reg    <= (s1_ri_reg == '0);
            s2_hz_reg    <= (s1_rhalf_reg == '0);
            s2_div_reg   <= (s1_tag_reg.cmd == cyc_pkg::CMD_AXIAL) ? s1_rhalf_reg : s1_ri_reg;
        end
    end

    // ---------------- stage 3: scaled terms ----------------
    logic              s3_valid_reg;
    cyc_pkg::cyc_tag_t s3_tag_reg;
    logic [52:0]       s3_t1m_reg;
    logic              s3_neg1_reg;
    logic [53:0]       s3_t1s_reg, s3_t2s_reg;
    logic [47:0]       s3_ax_reg;
    logic              s3_rz_reg, s3_hz_reg;
    logic [RW-1:0]     s3_div_reg;
    logic [73:0]       fa_sum, fh_sum;
    logic [47:0]       fa_s, fh_s;
    logic [52:0]       t1m, t2m;

    assign t1m    = s2_p1_reg[64:12];
    assign t2m    = s2_p2_reg[64:12];
    assign fa_sum = 74'(s2_fa_lo_reg) + {s2_fa_hi_reg, 32'h0};
    assign fh_sum = 74'(s2_fh_lo_reg) + {s2_fh_hi_reg, 32'h0};
    assign fa_s   = s2_nfa_reg ? 48'd0 - {2'b0, fa_sum[73:28]} : {2'b0, fa_sum[73:28]};
    assign fh_s   = s2_nfh_reg ? 48'd0 - {2'b0, fh_sum[73:28]} : {2'b0, fh_sum[73:28]};

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_tag_reg  <= s2_tag_reg;
            s3_t1m_reg  <= t1m;
            s3_neg1_reg <= s2_neg1_reg;
            s3_t1s_reg  <= s2_neg1_reg ? 54'd0 - {1'b0, t1m} : {1'b0, t1m};
            s3_t2s_reg  <= s2_neg2_reg ? 54'd0 - {1'b0, t2m} : {1'b0, t2m};
            s3_ax_reg   <= fa_s - fh_s;
            s3_rz_reg   <= s2_rz_reg;
            s3_hz_reg   <= s2_hz_reg;
            s3_div_reg  <= s2_div_reg;
        end
    end

    // ---------------- stage 4: radial weighting of the axial numerator ----------------
    logic              s4_valid_reg;
    cyc_pkg::cyc_tag_t s4_tag_reg;
    logic [52:0]       s4_t1m_reg;
    logic              s4_neg1_reg;
    logic [53:0]       s4_t1s_reg, s4_t2s_reg;
    logic              s4_axneg_reg;
    logic [55:0]       s4_lo_reg;
    logic [54:0]       s4_hi_reg;
    logic              s4_rz_reg, s4_hz_reg;
    logic [RW-1:0]     s4_div_reg;
    logic [46:0]       ax_mag;
    logic [47:0]       ax_abs;

    assign ax_abs = s3_ax_reg[47] ? 48'd0 - s3_ax_reg : s3_ax_reg;
    assign ax_mag = ax_abs[46:0];

    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_tag_reg   <= s3_tag_reg;
            s4_t1m_reg   <= s3_t1m_reg;
            s4_neg1_reg  <= s3_neg1_reg;
            s4_t1s_reg   <= s3_t1s_reg;
            s4_t2s_reg   <= s3_t2s_reg;
            s4_axneg_reg <= s3_ax_reg[47];
            s4_lo_reg    <= 56'(ax_mag[23:0]) * 56'(cfg.inv_radial);
            s4_hi_reg    <= 55'(ax_mag[46:24]) * 55'(cfg.inv_radial);
            s4_rz_reg    <= s3_rz_reg;
            s4_hz_reg    <= s3_hz_reg;
            s4_div_reg   <= s3_div_reg;
        end
    end

    // ---------------- stage 5: clamp of the weighted term ----------------
    logic              s5_valid_reg;
    cyc_pkg::cyc_tag_t s5_tag_reg;
    logic [52:0]       s5_t1m_reg;
    logic              s5_neg1_reg;
    logic [53:0]       s5_t1s_reg, s5_t2s_reg;
    logic [63:0]       s5_axs_reg;
    logic              s5_rz_reg, s5_hz_reg;
    logic [RW-1:0]     s5_div_reg;
    logic [79:0]       ax_full;
    logic [67:0]       ax_q;
    logic [63:0]       ax_c;

    assign ax_full = 80'(s4_lo_reg) + {1'b0, s4_hi_reg, 24'h0};
    assign ax_q    = ax_full[79:12];
    assign ax_c    = (ax_q > 68'(cyc_pkg::LIM64)) ? cyc_pkg::LIM64 : ax_q[63:0];

    always_ff @(posedge aclk) begin
        if (adv) begin
            s5_tag_reg  <= s4_tag_reg;
            s5_t1m_reg  <= s4_t1m_reg;
            s5_neg1_reg <= s4_neg1_reg;
            s5_t1s_reg  <= s4_t1s_reg;
            s5_t2s_reg  <= s4_t2s_reg;
            s5_axs_reg  <= s4_axneg_reg ? 64'd0 - ax_c : ax_c;
            s5_rz_reg   <= s4_rz_reg;
            s5_hz_reg   <= s4_hz_reg;
            s5_div_reg  <= s4_div_reg;
        end
    end

    // ---------------- stage 6: numerator, offset and divider setup ----------------
    logic                  s6_valid_reg;
    cyc_pkg::cyc_div_in_t  s6_data_reg;
    cyc_pkg::cyc_div_in_t  s6_data_next;
    logic [63:0]           t1x, t2x, num, numc, num_abs;

    assign t1x = {{10{s5_t1s_reg[53]}}, s5_t1s_reg};
    assign t2x = {{10{s5_t2s_reg[53]}}, s5_t2s_reg};
    assign num = s5_axs_reg - t2x;

    always_comb begin
        if ($signed(num) > $signed(cyc_pkg::LIM64)) begin
            numc = cyc_pkg::LIM64;
        end else if ($signed(num) < -$signed(cyc_pkg::LIM64)) begin
            numc = 64'd0 - cyc_pkg::LIM64;
        end else begin
            numc = num;
        end
        num_abs = numc[63] ? 64'd0 - numc : numc;

        s6_data_next           = '0;
        s6_data_next.tag       = s5_tag_reg;
        s6_data_next.divisor   = s5_div_reg;
        unique case (s5_tag_reg.cmd)
            cyc_pkg::CMD_RADIAL: begin
                // On the axis the angular term is dropped.
                s6_data_next.offset  = 64'd0 - t2x;
                s6_data_next.use_div = !s5_rz_reg;
                s6_data_next.neg     = s5_neg1_reg;
                s6_data_next.mag     = 61'(s5_t1m_reg);
            end
            cyc_pkg::CMD_AZIMUTHAL: begin
                s6_data_next.offset = t1x - t2x;
            end
            cyc_pkg::CMD_AXIAL: begin
                if (s5_hz_reg) begin
                    // Zero divisor: full scale by the numerator's sign, zero for a zero numerator.
                    s6_data_next.force_sat = 1'b1;
                    s6_data_next.offset    = numc[63] ? 64'd0 - cyc_pkg::LIM64 :
                                             ((numc == '0) ? 64'd0 : cyc_pkg::LIM64);
                end else begin
                    s6_data_next.use_div = 1'b1;
                    s6_data_next.neg     = numc[63];
                    s6_data_next.mag     = num_abs[60:0];
                end
            end
            cyc_pkg::CMD_UNUSED: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s6_data_reg <= s6_data_next;
        end
    end

    // Valid bits travel with the words.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    assign out_valid = s6_valid_reg;
    assign out_data  = s6_data_reg;

endmodule

`default_nettype wire

// ===== hdl/cyc_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, x * 2^28 / r.
`default_nettype none

module cyc_div (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 adv,
    input  wire logic                 in_valid,
    input  wire cyc_pkg::cyc_div_in_t in_data,
    output logic                      out_valid,
    output cyc_pkg::cyc_div_out_t     out_data
);

    localparam int RW = cyc_pkg::RW;
    localparam int NS = cyc_pkg::DIV_STEPS;

    typedef struct packed {
        cyc_pkg::cyc_tag_t tag;
        logic              use_div;
        logic              neg;
        logic              force_sat;
        logic [63:0]       offset;
        logic              ovf;
        logic [RW-1:0]     divisor;
        logic [RW-1:0]     rem;
        logic [NS-1:0]     low;
        logic [NS-1:0]     quot;
    } div_stage_t;

    div_stage_t  st_reg       [NS+1];
    logic        st_valid_reg [NS+1];
    logic [RW:0] rem2         [1:NS];
    logic        ge           [1:NS];

    // Trial subtraction of each stage.
    for (genvar g = 1; g <= NS; g++) begin : g_step
        assign rem2[g] = {st_reg[g-1].rem, st_reg[g-1].low[NS-1]};
        assign ge[g]   = rem2[g] >= {1'b0, st_reg[g-1].divisor};
    end

    // Setup stage with the overflow test and the leading partial remainder,
    // then one quotient bit per stage.
    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg[0].tag       <= in_data.tag;
            st_reg[0].use_div   <= in_data.use_div;
            st_reg[0].neg       <= in_data.neg;
            st_reg[0].force_sat <= in_data.force_sat;
            st_reg[0].offset    <= in_data.offset;
            st_reg[0].ovf       <= {7'b0, in_data.mag} >= {in_data.divisor, 26'h0};
            st_reg[0].divisor   <= in_data.divisor;
            st_reg[0].rem       <= RW'(in_data.mag[60:cyc_pkg::DIV_PRE]);
            st_reg[0].low       <= {in_data.mag[cyc_pkg::DIV_PRE-1:0], 28'h0};
            st_reg[0].quot      <= '0;
            for (int n = 1; n <= NS; n++) begin
                st_reg[n].tag       <= st_reg[n-1].tag;
                st_reg[n].use_div   <= st_reg[n-1].use_div;
                st_reg[n].neg       <= st_reg[n-1].neg;
                st_reg[n].force_sat <= st_reg[n-1].force_sat;
                st_reg[n].offset    <= st_reg[n-1].offset;
                st_reg[n].ovf       <= st_reg[n-1].ovf;
                st_reg[n].divisor   <= st_reg[n-1].divisor;
                st_reg[n].rem       <= ge[n] ? RW'(rem2[n] - {1'b0, st_reg[n-1].divisor})
                                             : RW'(rem2[n]);
                st_reg[n].low       <= {st_reg[n-1].low[NS-2:0], 1'b0};
                st_reg[n].quot      <= {st_reg[n-1].quot[NS-2:0], ge[n]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n <= NS; n++) begin
                st_valid_reg[n] <= 1'b0;
            end
        end else if (adv) begin
            st_valid_reg[0] <= in_valid;
            for (int n = 1; n <= NS; n++) begin
                st_valid_reg[n] <= st_valid_reg[n-1];
            end
        end
    end

    // A quotient of 2^54 or more stands as 2^54, which saturates later.
    assign out_valid          = st_valid_reg[NS];
    assign out_data.tag       = st_reg[NS].tag;
    assign out_data.use_div   = st_reg[NS].use_div;
    assign out_data.neg       = st_reg[NS].neg;
    assign out_data.force_sat = st_reg[NS].force_sat;
    assign out_data.offset    = st_reg[NS].offset;
    assign out_data.quot      = st_reg[NS].ovf ? {1'b1, {NS{1'b0}}} : {1'b0, st_reg[NS].quot};

endmodule

`default_nettype wire

// ===== sim/cylindrical_yee_curl_point_test.sv =====
// Self-checking testbench for the cylindrical Yee curl block with its own curl predictor.
`default_nettype none

module cylindrical_yee_curl_point_test;

    localparam logic [63:0] CLAMP_LIM   = 64'h1000_0000_0000_0000;
    localparam int          LATENCY     = 62;
    localparam int          CYCLE_LIMIT = 2_000_000;

    // One input word in field form.
    typedef struct {
        logic [1:0]  cmd;
        logic [8:0]  ri;
        logic [7:0]  aj;
        logic [8:0]  zk;
        logic [31:0] fa;
        logic [31:0] fh;
        logic [31:0] sa;
        logic [31:0] sh;
    } point_t;

    // One result word in field form.
    typedef struct {
        logic [31:0] value;
        logic [1:0]  comp;
        logic [8:0]  ri;
        logic [7:0]  aj;
        logic [8:0]  zk;
        logic        sat;
    } curl_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [159:0]               s_tdata;
    logic [1:0]                 s_tuser;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [63:0]                m_tdata;
    logic [2:0]                 m_tuser;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [cyc_pkg::CFG_AW-1:0] paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;

    // Local copy of the configuration registers.
    logic [31:0] cfg_inner;
    logic [31:0] cfg_step;
    logic [31:0] cfg_inv_r;
    logic [31:0] cfg_inv_phi;
    logic [31:0] cfg_inv_z;

    curl_t curl_expected[$];
    int    mismatches;
    int    cycles;
    bit    src_idle;
    bit    sink_idle;
    int    hold_req;

    cylindrical_yee_curl_point DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Clock and run limit.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout at %0t", $time);
            $display("** cylindrical_yee_curl_point: FAILED **");
            $finish;
        end
    end

    // Unsigned product shifted right, clipped to the intermediate limit.
    function automatic logic [63:0] scaled_mag(input logic [63:0] a, input logic [63:0] b,
                                               input int s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> s;
        if (p > {64'd0, CLAMP_LIM}) return CLAMP_LIM;
        return p[63:0];
    endfunction

    // Signed product by an unsigned scale, truncated toward zero.
    function automatic logic signed [63:0] scale_signed(input logic signed [63:0] x,
                                                        input logic [63:0] u, input int s);
        logic [63:0] m;
        m = (x < 0) ? -x : x;
        m = scaled_mag(m, u, s);
        return (x < 0) ? -$signed(m) : $signed(m);
    endfunction

    // Signed value times 2^28 over a radius, truncated toward zero.
    function automatic logic signed [63:0] over_radius(input logic signed [63:0] x,
                                                       input logic [63:0] d);
        logic [63:0]  m;
        logic [127:0] q;
        m = (x < 0) ? -x : x;
        if (m / d >= 64'h1_0000_0000) begin
            q = {64'd0, CLAMP_LIM};
        end else begin
            q = ({64'd0, m} << 28) / {64'd0, d};
            if (q > {64'd0, CLAMP_LIM}) q = {64'd0, CLAMP_LIM};
        end
        return (x < 0) ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    function automatic logic signed [63:0] clamp60(input logic signed [63:0] v);
        if (v > $signed(CLAMP_LIM)) return $signed(CLAMP_LIM);
        if (v < -$signed(CLAMP_LIM)) return -$signed(CLAMP_LIM);
        return v;
    endfunction

    // Curl component of one grid point under the current register settings.
    function automatic curl_t predict_curl(input point_t p);
        curl_t             c;
        logic signed [63:0] fa, fh, sa, sh, d1, d2, t1, t2, num, v;
        logic [63:0]       a, dr, i, r_i, r_next, r_half;
        fa = {{32{p.fa[31]}}, p.fa};
        fh = {{32{p.fh[31]}}, p.fh};
        sa = {{32{p.sa[31]}}, p.sa};
        sh = {{32{p.sh[31]}}, p.sh};
        d1 = fa - fh;
        d2 = sa - sh;
        a = {32'd0, cfg_inner};
        dr = {32'd0, cfg_step};
        i = {55'd0, p.ri};
        r_i = a + i * dr;
        r_next = a + (i + 1) * dr;
        r_half = (2 * a + (2 * i + 1) * dr) >> 1;
        v = 0;
        c.sat = 1'b0;
        case (p.cmd)
            cyc_pkg::CMD_RADIAL: begin
                t1 = scale_signed(d1, {32'd0, cfg_inv_phi}, 12);
                t2 = scale_signed(d2, {32'd0, cfg_inv_z}, 12);
                // On the axis only the axial term remains.
                if (r_i == 0) v = -t2;
                else v = clamp60(over_radius(t1, r_i) - t2);
            end
            cyc_pkg::CMD_AZIMUTHAL: begin
                t1 = scale_signed(d1, {32'd0, cfg_inv_z}, 12);
                t2 = scale_signed(d2, {32'd0, cfg_inv_r}, 12);
                v = clamp60(t1 - t2);
            end
            cyc_pkg::CMD_AXIAL: begin
                t1 = clamp60(scale_signed(fa, r_next, 28) - scale_signed(fh, r_i, 28));
                t1 = scale_signed(t1, {32'd0, cfg_inv_r}, 12);
                t2 = scale_signed(d2, {32'd0, cfg_inv_phi}, 12);
                num = clamp60(t1 - t2);
                // A zero half radius gives the extreme of the numerator's sign, or zero for a zero numerator.
                if (r_half == 0) begin
                    c.sat = 1'b1;
                    v = (num > 0) ? $signed(CLAMP_LIM) : ((num < 0) ? -$signed(CLAMP_LIM) : 0);
                end else begin
                    v = over_radius(num, r_half);
                end
            end
            default: v = 0;
        endcase
        if (v > 64'sd2147483647) begin
            v = 64'sd2147483647;
            c.sat = 1'b1;
        end
        if (v < -64'sd2147483648) begin
            v = -64'sd2147483648;
            c.sat = 1'b1;
        end
        c.value = v[31:0];
        c.comp = p.cmd;
        c.ri = p.ri;
        c.aj = p.aj;
        c.zk = p.zk;
        return c;
    endfunction

    // Send one word, with an optional idle burst ahead of it.
    task automatic send_point(input point_t p);
        if (src_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, p.sh, p.sa, p.fh, p.fa, p.zk, p.aj, p.ri};
        s_tuser <= p.cmd;
        do @(posedge aclk); while (!s_tready);
        curl_expected.push_back(predict_curl(p));
    endtask

    // Let the pipeline drain completely.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (curl_expected.size() != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
    endtask

    // Two-phase register write; the predictor copy follows it.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            cyc_pkg::REG_INNER_RADIUS: cfg_inner = value;
            cyc_pkg::REG_RADIAL_STEP:  cfg_step = value;
            cyc_pkg::REG_INV_RADIAL:   cfg_inv_r = value;
            cyc_pkg::REG_INV_ANGULAR:  cfg_inv_phi = value;
            default:                   cfg_inv_z = value;
        endcase
    endtask

    task automatic write_all(input logic [31:0] a, input logic [31:0] dr,
                             input logic [31:0] ir, input logic [31:0] ip,
                             input logic [31:0] iz);
        wait_idle();
        write_reg(cyc_pkg::REG_INNER_RADIUS, a);
        write_reg(cyc_pkg::REG_RADIAL_STEP, dr);
        write_reg(cyc_pkg::REG_INV_RADIAL, ir);
        write_reg(cyc_pkg::REG_INV_ANGULAR, ip);
        write_reg(cyc_pkg::REG_INV_AXIAL, iz);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Field sample: full range, modest, or an extreme.
    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return ($urandom_range(0, 1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    function automatic point_t rand_point();
        point_t p;
        p.cmd = ($urandom_range(0, 15) == 0) ? cyc_pkg::CMD_UNUSED : 2'($urandom_range(0, 2));
        p.ri = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 511))
                                           : 9'($urandom_range(0, 256));
        p.aj = 8'($urandom);
        p.zk = 9'($urandom);
        p.fa = rand_sample();
        p.fh = rand_sample();
        p.sa = rand_sample();
        p.sh = rand_sample();
        return p;
    endfunction

    function automatic point_t make_point(input logic [1:0] cmd, input logic [8:0] ri,
                                          input logic [31:0] fa, input logic [31:0] fh,
                                          input logic [31:0] sa, input logic [31:0] sh);
        point_t p;
        p.cmd = cmd;
        p.ri = ri;
        p.aj = ri[7:0] ^ 8'hA5;
        p.zk = ~ri;
        p.fa = fa;
        p.fh = fh;
        p.sa = sa;
        p.sh = sh;
        return p;
    endfunction

    // Directed words: every component, extremes of each field, the axis point.
    task automatic test_directed();
        logic [1:0] cmd;
        for (int c = 0; c < 4; c++) begin
            cmd = 2'(c);
            send_point(make_point(cmd, 9'd0, 32'h0001_0000, 32'h0, 32'h0002_0000, 32'h0));
            send_point(make_point(cmd, 9'd511, 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'h8000_0000, 32'h7FFF_FFFF));
            send_point(make_point(cmd, 9'd256, 32'h8000_0000, 32'h7FFF_FFFF,
                                  32'h7FFF_FFFF, 32'h8000_0000));
            send_point(make_point(cmd, 9'd1, 32'hFFFF_0000, 32'h0000_8000,
                                  32'h0, 32'hFFFF_FFFF));
        end
    endtask

    // Extreme register settings, including a zero radius grid and zero reciprocals.
    task automatic test_register_extremes();
        write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        test_directed();
        write_all(32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        test_directed();
        write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1000, 32'h1000, 32'h1000);
        test_directed();
    endtask

    // Random words under a random register setting.
    task automatic test_random(input int count);
        write_all($urandom_range(0, 32'h2000_0000), $urandom_range(1, 32'h0800_0000),
                  $urandom_range(0, 32'h0002_0000), $urandom_range(0, 32'h0002_0000),
                  ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h4000));
        for (int n = 0; n < count; n++) send_point(rand_point());
    endtask

    // Receiver holds off for a long stretch while words keep coming.
    task automatic test_backpressure();
        hold_req = 300;
        for (int n = 0; n < 150; n++) send_point(rand_point());
    endtask

    // Sender pauses mid-stream until every result has come back.
    task automatic test_pause();
        for (int n = 0; n < 40; n++) send_point(rand_point());
        s_tvalid <= 1'b0;
        while (curl_expected.size() != 0) @(posedge aclk);
        for (int n = 0; n < 40; n++) send_point(rand_point());
    endtask

    // Result readiness with random stalls and requested hold-offs.
    initial begin
        m_tready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (hold_req > 0) begin
                m_tready <= 1'b0;
                repeat (hold_req) @(posedge aclk);
                hold_req = 0;
                m_tready <= 1'b1;
            end else if (sink_idle && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each result word with the oldest prediction.
    always @(posedge aclk) begin
        curl_t c;
        if (aresetn && m_tvalid && m_tready) begin
            if (curl_expected.size() == 0) begin
                $display("%0t: unexpected result %h/%h", $time, m_tdata, m_tuser);
                mismatches++;
            end else begin
                c = curl_expected.pop_front();
                if (m_tdata[31:0] !== c.value) begin
                    $display("%0t: curl_value expected %h actual %h", $time, c.value,
                             m_tdata[31:0]);
                    mismatches++;
                end
                if (m_tdata[40:32] !== c.ri || m_tdata[48:41] !== c.aj ||
                    m_tdata[57:49] !== c.zk) begin
                    $display("%0t: indices expected %h %h %h actual %h %h %h", $time,
                             c.ri, c.aj, c.zk, m_tdata[40:32], m_tdata[48:41],
                             m_tdata[57:49]);
                    mismatches++;
                end
                if (m_tuser[1:0] !== c.comp) begin
                    $display("%0t: component expected %h actual %h", $time, c.comp,
                             m_tuser[1:0]);
                    mismatches++;
                end
                if (m_tuser[2] !== c.sat) begin
                    $display("%0t: saturated expected %b actual %b", $time, c.sat,
                             m_tuser[2]);
                    mismatches++;
                end
            end
        end
    end

    // Test sequence.
    initial begin
        cycles = 0;
        mismatches = 0;
        hold_req = 0;
        src_idle = 1'b1;
        sink_idle = 1'b1;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        cfg_inner = cyc_pkg::RST_INNER_RADIUS;
        cfg_step = cyc_pkg::RST_RADIAL_STEP;
        cfg_inv_r = cyc_pkg::RST_INV_STEP;
        cfg_inv_phi = cyc_pkg::RST_INV_STEP;
        cfg_inv_z = cyc_pkg::RST_INV_STEP;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_register_extremes();
        for (int k = 0; k < 4; k++) test_random(200);
        test_backpressure();
        test_pause();
        src_idle = 1'b0;
        sink_idle = 1'b0;
        test_random(200);

        wait_idle();
        if (mismatches == 0) begin
            $display("** cylindrical_yee_curl_point: PASSED **");
        end else begin
            $display("** cylindrical_yee_curl_point: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
